>>> rtl/lrpq_pkg.sv
// ============================================================================
// lrpq_pkg: shared definitions for the request priority queue
// Operation and status codes, default sizes, and the cell control and
// chain signal types.
// ============================================================================
package lrpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_SITE_BITS   = 4;

    localparam int FUNC_W   = 2;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // Operation broadcast to every cell in the accept cycle.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } lrpq_ctrl_t;

    // Signals that ripple from each cell to its right-hand neighbor.
    typedef struct packed {
        logic ins;  // insert point is at or left of this cell
        logic hit;  // a matching entry is at or left of this cell
    } lrpq_chain_t;

endpackage

>>> rtl/lamport_request_priority_queue_core.sv
// ============================================================================
// lamport_request_priority_queue_core: sorted access request queue
// Chain of cells that keeps requests ordered by timestamp and site.
// ============================================================================
// Requests are kept in ascending order of timestamp, ties broken by the
// smaller site. Every cell compares its entry with the request at once and
// the whole chain shifts in the accept cycle, so a command is taken on every
// clock (busy stays low) and its result appears with done in the cycle after
// the transfer. The receiver cannot stall: done is a one-cycle strobe and the
// result must be taken in that cycle. The longest path is the remove-match
// ripple through all QUEUE_DEPTH cells. Inserting into a full queue is dropped
// and flagged; removing an absent request reports not present.
module lamport_request_priority_queue_core
    import lrpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int SITE_BITS   = DEFAULT_SITE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [STAMP_W-1:0]   stamp,
    input  logic [SITE_BITS-1:0] site,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic                 is_first
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic                 is_first_reg;
    logic                 is_first_next;

    logic                 accept;
    logic                 full;
    logic                 found;
    lrpq_ctrl_t           ctrl;

    logic [STAMP_W-1:0]   cell_stamp [QUEUE_DEPTH];
    logic [SITE_BITS-1:0] cell_site  [QUEUE_DEPTH];
    lrpq_chain_t          chain      [QUEUE_DEPTH+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign found  = chain[QUEUE_DEPTH].hit;

    assign chain[0].ins = 1'b0;
    assign chain[0].hit = 1'b0;

    always_comb
    begin
        ctrl.do_insert = accept && (func == FUNC_INSERT) && !full;
        ctrl.do_remove = accept && (func == FUNC_REMOVE) && found;
    end

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            logic [STAMP_W-1:0]   l_stamp;
            logic [SITE_BITS-1:0] l_site;
            logic [STAMP_W-1:0]   r_stamp;
            logic [SITE_BITS-1:0] r_site;

            if (k == 0)
            begin : g_first
                assign l_stamp = stamp;
                assign l_site  = site;
            end
            else
            begin : g_mid
                assign l_stamp = cell_stamp[k-1];
                assign l_site  = cell_site[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_last
                assign r_stamp = cell_stamp[k];
                assign r_site  = cell_site[k];
            end
            else
            begin : g_inner
                assign r_stamp = cell_stamp[k+1];
                assign r_site  = cell_site[k+1];
            end

            lrpq_cell #(
                .SITE_BITS (SITE_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (COUNT_W'(k) < count_reg),
                .req_stamp   (stamp),
                .req_site    (site),
                .left_stamp  (l_stamp),
                .left_site   (l_site),
                .right_stamp (r_stamp),
                .right_site  (r_site),
                .chain_in    (chain[k]),
                .chain_out   (chain[k+1]),
                .stamp       (cell_stamp[k]),
                .site        (cell_site[k])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        status_next   = STATUS_DONE;
        is_first_next = 1'b0;
        if (accept)
        begin
            case (func)
                FUNC_INSERT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                FUNC_REMOVE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_ABSENT;
                    end
                end
                // The first cell's hit output is a match on the head entry.
                FUNC_QUERY:
                begin
                    is_first_next = chain[1].hit;
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        is_first_reg <= is_first_next;
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign is_first = is_first_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command gave no result");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_INSERT) && full) |=>
            (status == STATUS_FULL) && $stable(count_reg))
        else $error("insert into full queue not dropped");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_REMOVE) && found) |=>
            (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("remove did not shrink the queue");

    a_first_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_first) |-> (status == STATUS_DONE))
        else $error("head match reported with a failure status");

endmodule

>>> rtl/lrpq_cell.sv
// ============================================================================
// lrpq_cell: one slot of the sorted request chain
// Holds one entry, compares it with the incoming request, and loads the
// request or its left neighbor on insert, or its right neighbor on remove.
// ============================================================================
module lrpq_cell
    import lrpq_pkg::*;
#(
    parameter int SITE_BITS = DEFAULT_SITE_BITS
)
(
    input  logic                 clk,
    input  lrpq_ctrl_t           ctrl,
    input  logic                 occupied,
    input  logic [STAMP_W-1:0]   req_stamp,
    input  logic [SITE_BITS-1:0] req_site,
    input  logic [STAMP_W-1:0]   left_stamp,
    input  logic [SITE_BITS-1:0] left_site,
    input  logic [STAMP_W-1:0]   right_stamp,
    input  logic [SITE_BITS-1:0] right_site,
    input  lrpq_chain_t          chain_in,
    output lrpq_chain_t          chain_out,
    output logic [STAMP_W-1:0]   stamp,
    output logic [SITE_BITS-1:0] site
);

    logic [STAMP_W-1:0]   stamp_reg;
    logic [STAMP_W-1:0]   stamp_next;
    logic [SITE_BITS-1:0] site_reg;
    logic [SITE_BITS-1:0] site_next;
    logic                 goes_before;
    logic                 match;

    always_comb
    begin
        goes_before = occupied &&
                      ((req_stamp < stamp_reg) ||
                       ((req_stamp == stamp_reg) && (req_site < site_reg)));
        match = occupied && (req_stamp == stamp_reg) && (req_site == site_reg);

        // The chain is sorted, so the insert point is the first cell where
        // the request sorts strictly earlier or the first empty cell.
        chain_out.ins = goes_before || !occupied;
        chain_out.hit = chain_in.hit || match;

        stamp_next = stamp_reg;
        site_next  = site_reg;
        if (ctrl.do_insert)
        begin
            if (chain_in.ins)
            begin
                stamp_next = left_stamp;
                site_next  = left_site;
            end
            else if (chain_out.ins)
            begin
                stamp_next = req_stamp;
                site_next  = req_site;
            end
        end
        else if (ctrl.do_remove && chain_out.hit)
        begin
            stamp_next = right_stamp;
            site_next  = right_site;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        site_reg  <= site_next;
    end

    assign stamp = stamp_reg;
    assign site  = site_reg;

endmodule
